@@ hdl/sam_pkg.sv @@
// ----------------------------------------------------------------------------
// sam_pkg
// Shared types, sizes and helpers for the suffix automaton matcher.
// ----------------------------------------------------------------------------
package sam_pkg;

  localparam int MAX_TEXT   = 1024;
  localparam int ALPHABET   = 26;
  localparam int MAX_STATES = 2 * MAX_TEXT;
  localparam int ST_W       = $clog2(MAX_STATES);
  localparam int CNT_W      = $clog2(MAX_STATES + 1);
  localparam int LEN_W      = $clog2(MAX_TEXT + 1);
  localparam int TR_DEPTH   = MAX_STATES * ALPHABET;
  localparam int TR_AW      = $clog2(TR_DEPTH);
  localparam int CLR_W      = $clog2(TR_DEPTH + 1);
  localparam int COL_W      = $clog2(ALPHABET);
  localparam int SYM_W      = 5;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]       op;
    logic [SYM_W-1:0] symbol;
    logic             query_last;
  } in_t;

  typedef struct packed {
    logic found;
    logic overflowed;
  } out_t;

  typedef struct packed {
    logic [ST_W-1:0]  link;
    logic [LEN_W-1:0] len;
  } info_t;

  typedef struct packed {
    logic             we;
    logic [TR_AW-1:0] waddr;
    logic [ST_W-1:0]  wdata;
    logic [TR_AW-1:0] raddr;
  } tr_req_t;

  typedef struct packed {
    logic            we;
    logic [ST_W-1:0] waddr;
    info_t           wdata;
    logic [ST_W-1:0] raddr;
  } info_req_t;

  // Flat address of one transition entry: row * ALPHABET + column.
  function automatic logic [TR_AW-1:0] tr_addr(input logic [ST_W-1:0] row,
                                                input logic [7:0] col);
    logic [TR_AW-1:0] base;
    base = TR_AW'(row) * TR_AW'(ALPHABET);
    return base + TR_AW'(col);
  endfunction

endpackage

@@ hdl/sam_ram.sv @@
// ----------------------------------------------------------------------------
// sam_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/sam_ctrl.sv @@
// ----------------------------------------------------------------------------
// sam_ctrl
// Sequencer: clear pass, online construction with suffix-link walks and
// cloning, and query walks over the transition memory.
// ----------------------------------------------------------------------------
module sam_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  sam_pkg::in_t             in_data,
  input  logic                     out_busy,
  output logic                     res_valid,
  output sam_pkg::out_t            res,
  output sam_pkg::tr_req_t         tr_req,
  input  logic [sam_pkg::ST_W-1:0] tr_rdata,
  output sam_pkg::info_req_t       info_req,
  input  sam_pkg::info_t           info_rdata
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_Q_RD, S_Q_END, S_W_RD, S_W_LNK, S_H_LP, S_H_LQ,
    S_CPY, S_R_RD, S_R_LNK, S_FIN_Q, S_A_DONE
  } state_t;

  state_t                        state;
  logic [sam_pkg::CLR_W-1:0]     clr_addr;
  logic [sam_pkg::CLR_W-1:0]     clr_end;
  logic [sam_pkg::CNT_W-1:0]     count;
  logic [sam_pkg::ST_W-1:0]      last;
  logic [sam_pkg::LEN_W-1:0]     last_len;
  logic [sam_pkg::ST_W-1:0]      walk;
  logic                          ok;
  logic                          ovf;
  logic                          qlast;
  logic [sam_pkg::ST_W-1:0]      p;
  logic [sam_pkg::ST_W-1:0]      q;
  logic [sam_pkg::ST_W-1:0]      r;
  logic [sam_pkg::ST_W-1:0]      u;
  logic [sam_pkg::SYM_W-1:0]     c;
  logic [sam_pkg::LEN_W-1:0]     len_p;
  logic [sam_pkg::LEN_W-1:0]     len_q;
  logic [sam_pkg::ST_W-1:0]      link_u;
  logic [sam_pkg::COL_W-1:0]     cpy_k;

  logic accept;
  logic sym_ok;
  logic room;
  logic clone;
  logic [sam_pkg::LEN_W-1:0] len_p1;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign sym_ok    = 32'(in_data.symbol) < sam_pkg::ALPHABET;
  assign room      = 32'(last_len) < sam_pkg::MAX_TEXT;
  assign len_p1    = len_p + sam_pkg::LEN_W'(1);
  assign clone     = (len_p1 != info_rdata.len);
  assign res_valid = (state == S_Q_END) && !out_busy;
  assign res.found      = ok;
  assign res.overflowed = ovf;

  // Memory requests
  always_comb begin
    tr_req   = '0;
    info_req = '0;
    unique case (state)
      S_CLEAR: begin
        tr_req.we    = 1'b1;
        tr_req.waddr = clr_addr[sam_pkg::TR_AW-1:0];
      end
      S_IDLE: begin
        if (in_data.op == sam_pkg::OP_APPEND) begin
          tr_req.raddr = sam_pkg::tr_addr(last, 8'(in_data.symbol));
        end else begin
          tr_req.raddr = sam_pkg::tr_addr(walk, 8'(in_data.symbol));
        end
      end
      S_W_RD: begin
        if (tr_rdata == '0) begin
          tr_req.we    = 1'b1;
          tr_req.waddr = sam_pkg::tr_addr(p, 8'(c));
          tr_req.wdata = u;
          info_req.raddr = p;
        end else begin
          info_req.raddr = (p == '0) ? tr_rdata : p;
        end
      end
      S_W_LNK, S_R_LNK: begin
        tr_req.raddr = sam_pkg::tr_addr(info_rdata.link, 8'(c));
      end
      S_H_LP: begin
        info_req.raddr = q;
      end
      S_H_LQ: begin
        if (clone) begin
          info_req.we         = 1'b1;
          info_req.waddr      = count[sam_pkg::ST_W-1:0];
          info_req.wdata.link = info_rdata.link;
          info_req.wdata.len  = len_p1;
        end
        tr_req.raddr = sam_pkg::tr_addr(q, 8'd0);
      end
      S_CPY: begin
        tr_req.we    = 1'b1;
        tr_req.waddr = sam_pkg::tr_addr(r, 8'(cpy_k));
        tr_req.wdata = tr_rdata;
        if (32'(cpy_k) == sam_pkg::ALPHABET - 1) begin
          tr_req.raddr = sam_pkg::tr_addr(p, 8'(c));
        end else begin
          tr_req.raddr = sam_pkg::tr_addr(q, 8'(cpy_k) + 8'd1);
        end
      end
      S_R_RD: begin
        if (tr_rdata == q) begin
          tr_req.we    = 1'b1;
          tr_req.waddr = sam_pkg::tr_addr(p, 8'(c));
          tr_req.wdata = r;
        end
        info_req.raddr = p;
      end
      S_FIN_Q: begin
        info_req.we         = 1'b1;
        info_req.waddr      = q;
        info_req.wdata.link = r;
        info_req.wdata.len  = len_q;
      end
      S_A_DONE: begin
        info_req.we         = 1'b1;
        info_req.waddr      = u;
        info_req.wdata.link = link_u;
        info_req.wdata.len  = last_len + sam_pkg::LEN_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      clr_end  <= sam_pkg::CLR_W'(sam_pkg::TR_DEPTH);
      count    <= sam_pkg::CNT_W'(1);
      last     <= '0;
      last_len <= '0;
      walk     <= '0;
      ok       <= 1'b1;
      ovf      <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + sam_pkg::CLR_W'(1);
          if (clr_addr == clr_end - sam_pkg::CLR_W'(1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (in_data.op)
              sam_pkg::OP_START: begin
                clr_addr <= '0;
                clr_end  <= sam_pkg::CLR_W'(count) * sam_pkg::CLR_W'(sam_pkg::ALPHABET);
                count    <= sam_pkg::CNT_W'(1);
                last     <= '0;
                last_len <= '0;
                walk     <= '0;
                ok       <= 1'b1;
                ovf      <= 1'b0;
                state    <= S_CLEAR;
              end
              sam_pkg::OP_APPEND: begin
                if (sym_ok) begin
                  if (!room) begin
                    ovf <= 1'b1;
                  end else begin
                    u     <= count[sam_pkg::ST_W-1:0];
                    count <= count + sam_pkg::CNT_W'(1);
                    c     <= in_data.symbol;
                    p     <= last;
                    state <= S_W_RD;
                  end
                end
              end
              sam_pkg::OP_QUERY: begin
                qlast <= in_data.query_last;
                if (sym_ok) begin
                  state <= S_Q_RD;
                end else begin
                  walk <= '0;
                  ok   <= 1'b0;
                  if (in_data.query_last) begin
                    state <= S_Q_END;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_Q_RD: begin
          walk <= tr_rdata;
          if (tr_rdata == '0) begin
            ok <= 1'b0;
          end
          state <= qlast ? S_Q_END : S_IDLE;
        end
        S_Q_END: begin
          if (!out_busy) begin
            walk  <= '0;
            ok    <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_W_RD: begin
          if (tr_rdata == '0) begin
            if (p == '0) begin
              link_u <= '0;
              state  <= S_A_DONE;
            end else begin
              state <= S_W_LNK;
            end
          end else begin
            q <= tr_rdata;
            if (p == '0) begin
              len_p <= '0;
              state <= S_H_LQ;
            end else begin
              state <= S_H_LP;
            end
          end
        end
        S_W_LNK: begin
          p     <= info_rdata.link;
          state <= S_W_RD;
        end
        S_H_LP: begin
          len_p <= info_rdata.len;
          state <= S_H_LQ;
        end
        S_H_LQ: begin
          len_q <= info_rdata.len;
          if (!clone) begin
            link_u <= q;
            state  <= S_A_DONE;
          end else begin
            r     <= count[sam_pkg::ST_W-1:0];
            count <= count + sam_pkg::CNT_W'(1);
            cpy_k <= '0;
            state <= S_CPY;
          end
        end
        S_CPY: begin
          if (32'(cpy_k) == sam_pkg::ALPHABET - 1) begin
            state <= S_R_RD;
          end else begin
            cpy_k <= cpy_k + sam_pkg::COL_W'(1);
          end
        end
        S_R_RD: begin
          if (tr_rdata != q || p == '0) begin
            state <= S_FIN_Q;
          end else begin
            state <= S_R_LNK;
          end
        end
        S_R_LNK: begin
          p     <= info_rdata.link;
          state <= S_R_RD;
        end
        S_FIN_Q: begin
          link_u <= r;
          state  <= S_A_DONE;
        end
        S_A_DONE: begin
          last     <= u;
          last_len <= last_len + sam_pkg::LEN_W'(1);
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/suffix_automaton_matcher.sv @@
// ----------------------------------------------------------------------------
// suffix_automaton_matcher
// Online suffix automaton over a letter text with substring queries.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with in_data {op, symbol, query_last}.
//   A start request empties the automaton, an append request extends the text
//   by one letter, query requests walk a pattern one letter at a time. The
//   request with query_last set returns one result {found, overflowed} on
//   out_valid/out_ready; every other request returns nothing.
//   One request is in flight at a time; in_ready is high only when idle.
//   A query letter reads its transition; the last letter of a pattern then
//   waits to hand over its result. Append walks suffix links, reads lengths
//   when an existing transition is hit; a clone copies the row of 26 entries
//   through the single transition read port and then redirects transitions.
//   Start clears the used transition rows, 26 entries per state in use.
//   After reset the block sweeps all 53248 transition entries to zero, one
//   per cycle, with in_ready low.
//   A result sits in an output register; a stalled receiver holds it there
//   and a following pattern end waits until the register is free. Other
//   requests keep flowing while the result waits.
// ----------------------------------------------------------------------------
module suffix_automaton_matcher (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sam_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sam_pkg::out_t out_data
);

  sam_pkg::tr_req_t           tr_req;
  sam_pkg::info_req_t         info_req;
  logic [sam_pkg::ST_W-1:0]   tr_rdata;
  sam_pkg::info_t             info_rdata;
  logic                       res_valid;
  sam_pkg::out_t              res;
  logic                       out_busy;

  // Hold the result while the receiver stalls.
  assign out_busy = out_valid && !out_ready;

  sam_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_busy   (out_busy),
    .res_valid  (res_valid),
    .res        (res),
    .tr_req     (tr_req),
    .tr_rdata   (tr_rdata),
    .info_req   (info_req),
    .info_rdata (info_rdata)
  );

  // Transition table: one row of ALPHABET target states per state.
  sam_ram #(
    .WIDTH (sam_pkg::ST_W),
    .DEPTH (sam_pkg::TR_DEPTH)
  ) u_tr_ram (
    .clk   (clk),
    .we    (tr_req.we),
    .waddr (tr_req.waddr),
    .wdata (tr_req.wdata),
    .raddr (tr_req.raddr),
    .rdata (tr_rdata)
  );

  // Per-state suffix link and length.
  sam_ram #(
    .WIDTH ($bits(sam_pkg::info_t)),
    .DEPTH (sam_pkg::MAX_STATES)
  ) u_info_ram (
    .clk   (clk),
    .we    (info_req.we),
    .waddr (info_req.waddr),
    .wdata (info_req.wdata),
    .raddr (info_req.raddr),
    .rdata (info_rdata)
  );

  // Output register: load on a new result, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data <= res;
    end
  end

endmodule

@@ hdl/sam_chk.sv @@
// ----------------------------------------------------------------------------
// sam_chk
// Port-level checks for the suffix automaton matcher.
// ----------------------------------------------------------------------------
module sam_chk (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input sam_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input sam_pkg::out_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Reset starts the clear sweep.
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("ready right after reset");

  // A start request clears rows before taking more requests.
  a_start_clear: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.op == sam_pkg::OP_START |=> !in_ready)
    else $error("ready right after start");

  // Only a query request produces a new result.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.op != sam_pkg::OP_QUERY |=> !$rose(out_valid))
    else $error("result without query");

endmodule

bind suffix_automaton_matcher sam_chk u_sam_chk (.*);

@@ tb/sam_scoreboard.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sam_scoreboard
// Watches both channels of the suffix automaton matcher, keeps a shadow
// automaton built from the accepted requests, and checks every result.
// ----------------------------------------------------------------------------
module sam_scoreboard (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  sam_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  sam_pkg::out_t out_data,
  output int            errors,
  output int            pending,
  output int            results_seen
);

  int unsigned    next_state [sam_pkg::MAX_STATES][sam_pkg::ALPHABET];
  int unsigned    link_of [sam_pkg::MAX_STATES];
  int unsigned    len_of [sam_pkg::MAX_STATES];
  int unsigned    n_states;
  int unsigned    tail;
  int unsigned    walk_at;
  bit             walk_good;
  bit             dropped;
  sam_pkg::out_t  answers [$];

  function automatic int unsigned clip(int unsigned s);
    return (s < sam_pkg::MAX_STATES) ? s : 0;
  endfunction

  task automatic clear_text();
    for (int s = 0; s < sam_pkg::MAX_STATES; s++)
      for (int c = 0; c < sam_pkg::ALPHABET; c++) next_state[s][c] = 0;
    n_states = 1;
    tail = 0;
    link_of[0] = 0;
    len_of[0] = 0;
    walk_at = 0;
    walk_good = 1;
    dropped = 0;
  endtask

  task automatic extend_text(int unsigned c);
    int unsigned u, p, q, r;
    bit hit;
    hit = 0;
    if (len_of[clip(tail)] >= sam_pkg::MAX_TEXT) begin
      dropped = 1;
      return;
    end
    u = clip(n_states);
    n_states++;
    len_of[u] = len_of[clip(tail)] + 1;
    p = tail;
    forever begin
      if (next_state[clip(p)][c] != 0) begin
        hit = 1;
        break;
      end
      next_state[clip(p)][c] = u;
      if (clip(p) == 0) break;
      p = link_of[clip(p)];
    end
    if (!hit) begin
      link_of[u] = 0;
    end else begin
      q = clip(next_state[clip(p)][c]);
      if (len_of[clip(p)] + 1 == len_of[q]) begin
        link_of[u] = q;
      end else begin
        // split q: the clone takes its outgoing row and suffix link
        r = clip(n_states);
        n_states++;
        len_of[r] = len_of[clip(p)] + 1;
        link_of[r] = link_of[q];
        for (int k = 0; k < sam_pkg::ALPHABET; k++) next_state[r][k] = next_state[q][k];
        forever begin
          if (next_state[clip(p)][c] != q) break;
          next_state[clip(p)][c] = r;
          if (clip(p) == 0) break;
          p = link_of[clip(p)];
        end
        link_of[q] = r;
        link_of[u] = r;
      end
    end
    tail = u;
  endtask

  initial begin
    errors = 0;
    results_seen = 0;
    pending = 0;
    clear_text();
  end

  always @(posedge clk) begin
    sam_pkg::out_t got, want;
    if (!rst && in_valid && in_ready) begin
      case (in_data.op)
        sam_pkg::OP_START: clear_text();
        sam_pkg::OP_APPEND: if (in_data.symbol < sam_pkg::ALPHABET) extend_text(in_data.symbol);
        sam_pkg::OP_QUERY: begin
          if (in_data.symbol < sam_pkg::ALPHABET) begin
            walk_at = clip(next_state[walk_at][in_data.symbol]);
            if (walk_at == 0) walk_good = 0;
          end else begin
            walk_at = 0;
            walk_good = 0;
          end
          if (in_data.query_last) begin
            want.found = walk_good;
            want.overflowed = dropped;
            answers.push_back(want);
            walk_at = 0;
            walk_good = 1;
          end
        end
        default: ;
      endcase
    end
    if (!rst && out_valid && out_ready) begin
      got = out_data;
      results_seen++;
      if (answers.size() == 0) begin
        $error("result with no query pending: found=%0d overflowed=%0d",
               got.found, got.overflowed);
        errors++;
      end else begin
        want = answers.pop_front();
        if (got.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, got.found);
          errors++;
        end
        if (got.overflowed !== want.overflowed) begin
          $error("overflowed: expected %0d, got %0d", want.overflowed, got.overflowed);
          errors++;
        end
      end
    end
    pending = answers.size();
  end
endmodule

@@ tb/tb_suffix_automaton_matcher.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_suffix_automaton_matcher
// Drives texts, appends and substring queries into the matcher with random
// gaps and receiver stalls; the scoreboard predicts and checks each result.
// ----------------------------------------------------------------------------
module tb_suffix_automaton_matcher;

  // Op code the block leaves unused.
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic          clk = 0;
  logic          rst = 1;
  logic          in_valid = 0;
  logic          in_ready;
  sam_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 0;
  sam_pkg::out_t out_data;
  int   errors, pending, results_seen;
  int   requests_sent = 0;
  bit   stim_done = 0;
  bit   hold_off = 0;

  always #2 clk = ~clk;

  suffix_automaton_matcher dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  sam_scoreboard sb (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  // Gap length: mostly none or short, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Offer one request and hold it until the block takes it.
  task automatic send(logic [1:0] op, logic [sam_pkg::SYM_W-1:0] sym, logic last);
    int g;
    sam_pkg::in_t req;
    g = gap_len();
    req.op = op;
    req.symbol = sym;
    req.query_last = last;
    @(negedge clk);
    if (g > 0) begin
      in_valid <= 1'b0;
      in_data  <= ($bits(sam_pkg::in_t))'($urandom);
      repeat (g) @(negedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    requests_sent++;
  endtask

  // Query a pattern of n symbols; random symbols mostly from a small alphabet
  // so that hits are frequent.
  task automatic query_random(int n, int span);
    for (int i = 0; i < n; i++)
      send(sam_pkg::OP_QUERY, sam_pkg::SYM_W'($urandom_range(0, span - 1)), i == n - 1);
  endtask

  // Receiver: random stalls, and one long hold-off on request.
  initial begin
    int g;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 0;
      end else begin
        g = gap_len();
        if (g > 0) begin
          out_ready <= 0;
          repeat (g) begin
            @(negedge clk);
            if (hold_off) break;
          end
        end
        if (!hold_off) out_ready <= 1;
      end
    end
  end

  // Stimulus
  initial begin
    int span, n, wait_cnt;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: queries on the empty text, extreme symbols, bad codes
    query_random(1, 26);
    send(sam_pkg::OP_APPEND, 0, 0);
    send(sam_pkg::OP_APPEND, 25, 1);
    send(sam_pkg::OP_APPEND, 0, 0);
    send(sam_pkg::OP_APPEND, 0, 0);
    send(sam_pkg::OP_APPEND, 31, 0);   // bad letter, ignored
    send(OP_SPARE, 5'd7, 1'b1);        // unused op, ignored
    send(sam_pkg::OP_QUERY, 0, 1);
    send(sam_pkg::OP_QUERY, 25, 0);
    send(sam_pkg::OP_QUERY, 0, 1);
    send(sam_pkg::OP_QUERY, 26, 1);    // bad letter in a query
    send(sam_pkg::OP_QUERY, 31, 0);
    send(sam_pkg::OP_QUERY, 0, 1);     // walk resumes after a miss
    send(sam_pkg::OP_QUERY, 0, 0);
    send(sam_pkg::OP_APPEND, 1, 0);    // append in the middle of a walk
    send(sam_pkg::OP_QUERY, 1, 1);
    send(sam_pkg::OP_QUERY, 3, 1);
    send(sam_pkg::OP_START, 31, 1);
    send(sam_pkg::OP_QUERY, 0, 1);

    // Long receiver hold-off while the sender keeps going
    hold_off = 1;
    fork
      begin
        wait_cnt = 0;
        while (wait_cnt < 3000) begin
          @(negedge clk);
          wait_cnt++;
        end
        hold_off = 0;
      end
      begin
        for (int i = 0; i < 6; i++) send(sam_pkg::OP_APPEND, sam_pkg::SYM_W'(i % 2), 1'b0);
        for (int i = 0; i < 8; i++) query_random(1, 2);
      end
    join

    // Random: texts of varied size over varied alphabets, queries mixed in
    while (requests_sent < 800) begin
      send(sam_pkg::OP_START, sam_pkg::SYM_W'($urandom_range(0, 31)),
           1'($urandom_range(0, 1)));
      span = ($urandom_range(0, 3) == 0) ? 26 : $urandom_range(2, 4);
      n = $urandom_range(0, 60);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) < 7)
          send(sam_pkg::OP_APPEND, sam_pkg::SYM_W'($urandom_range(0, span - 1)),
               1'($urandom_range(0, 1)));
        else
          query_random($urandom_range(1, 5), span);
        if ($urandom_range(0, 49) == 0)
          send($urandom_range(0, 1) ? OP_SPARE : sam_pkg::OP_APPEND,
               sam_pkg::SYM_W'($urandom_range(26, 31)), 1'($urandom_range(0, 1)));
      end
      repeat ($urandom_range(2, 6)) query_random($urandom_range(1, 6), span);
    end

    send(sam_pkg::OP_START, 0, 0);
    query_random(1, 3);

    @(negedge clk);
    in_valid <= 1'b0;
    stim_done = 1;
  end

  // Drain and verdict
  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered %0d requests and %0d pattern results over random texts,",
             requests_sent, results_seen);
    $display("bad codes, and a long receiver hold-off that stalled the input.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end
endmodule
